@@ src/sspr_pkg.sv @@
// ----------------------------------------------------------------------------
// sspr_pkg: shared types and constants of the servo status packet receiver
// Commands, status codes, register indexes, channel words and the control
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sspr_pkg;

  localparam int MaxPacketDef = 16;
  localparam int MinPacket    = 6;
  localparam int LenOverhead  = 4;
  localparam logic [7:0] HeaderByte = 8'hFF;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgTimeout = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgReqZero = 1'b1;
  localparam logic [15:0] TimeoutReset = 16'd10;

  typedef enum logic [1:0] {
    CMD_ARM  = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_MISMATCH = 2'd1,
    STS_TIMEOUT  = 2'd2,
    STS_BAD_REQ  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HUNT    = 3'b010,
    PH_COLLECT = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    CS_WAIT = 3'b001,
    CS_RD   = 3'b010,
    CS_LD   = 3'b100
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [7:0] servo_id;
    logic [7:0] expected_len;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] device_error;
    logic       has_param;
    logic [5:0] param_index;
    logic [7:0] param_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic step;
    logic load_param;
  } ctrl_cmd_t;

  typedef struct packed {
    logic burst_start;
    logic idx_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ src/sspr_if.sv @@
// ----------------------------------------------------------------------------
// sspr_if: valid/ready channels of the servo status packet receiver
// One interface for input words, one for result words.
// ----------------------------------------------------------------------------
interface sspr_in_if;
  import sspr_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sspr_out_if;
  import sspr_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/servo_status_packet_receiver.sv @@
// ----------------------------------------------------------------------------
// servo_status_packet_receiver: servo status packet receiver
// Checks a servo status packet fed one UART byte at a time and returns its
// parameter bytes with a status.
// ----------------------------------------------------------------------------
// Input channel item_i carries one word per arm command, received byte or
// millisecond tick. Result channel result_o carries status words; a good
// packet gives one word per parameter byte, the last one marked by last.
// The configuration port writes the timeout (index 0) and the zero device
// error requirement (index 1); the user writes them only while the block
// is idle, which the block itself does not enforce. A word that ends a
// request with a single result shows it on result_o the cycle after it is
// accepted. The final byte of a good packet with N parameters starts a
// burst of N words, each read from the parameter store (registered read)
// and then loaded; no input word is taken until the last of them is loaded.
// Input is taken only while the output register is empty or being drained,
// so a stalled receiver holds the block. Reset leaves the block idle with
// a timeout of 10 ticks and the zero error check on; no clearing pass.
// ----------------------------------------------------------------------------
module servo_status_packet_receiver #(
  parameter int MAX_PACKET = sspr_pkg::MaxPacketDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sspr_in_if.sink                       item_i,
  sspr_out_if.source                    result_o,
  input  logic                          cfg_we_i,
  input  logic [sspr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sspr_pkg::CfgDataW-1:0] cfg_data_i
);
  import sspr_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  sspr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sspr_dpath #(
    .MAX_PACKET (MAX_PACKET)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (item_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_data_o  (result_o.data)
  );

endmodule

@@ src/sspr_ram.sv @@
// ----------------------------------------------------------------------------
// sspr_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sspr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 10,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sspr_ctrl.sv @@
// ----------------------------------------------------------------------------
// sspr_ctrl: controller of the servo status packet receiver
// Takes input words and sequences the parameter burst out of the store.
// ----------------------------------------------------------------------------
module sspr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sspr_pkg::dp_sts_t   sts_i,
  output sspr_pkg::ctrl_cmd_t cmd_o
);
  import sspr_pkg::*;

  ctrl_state_e state_q, state_d;

  assign in_ready_o = (state_q == CS_WAIT) && sts_i.out_free;

  always_comb begin
    state_d          = state_q;
    cmd_o.step       = 1'b0;
    cmd_o.load_param = 1'b0;
    case (state_q)
      CS_WAIT: begin
        cmd_o.step = in_valid_i && sts_i.out_free;
        if (cmd_o.step && sts_i.burst_start) begin
          state_d = CS_RD;
        end
      end
      CS_RD: begin
        // read data shows up next cycle
        state_d = CS_LD;
      end
      CS_LD: begin
        if (sts_i.out_free) begin
          cmd_o.load_param = 1'b1;
          state_d = sts_i.idx_last ? CS_WAIT : CS_RD;
        end
      end
      default: begin
        state_d = CS_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_WAIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/sspr_dpath.sv @@
// ----------------------------------------------------------------------------
// sspr_dpath: datapath of the servo status packet receiver
// Packet state, checks, parameter store and the output register.
// ----------------------------------------------------------------------------
module sspr_dpath #(
  parameter int MAX_PACKET = sspr_pkg::MaxPacketDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sspr_pkg::in_word_t            in_data_i,
  input  sspr_pkg::ctrl_cmd_t           cmd_i,
  output sspr_pkg::dp_sts_t             sts_o,
  input  logic                          cfg_we_i,
  input  logic [sspr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sspr_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sspr_pkg::out_word_t           out_data_o
);
  import sspr_pkg::*;

  localparam int ParamDepth = MAX_PACKET - MinPacket;
  localparam int StoreDepth = (ParamDepth > 0) ? ParamDepth : 1;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int LenW       = $clog2(MAX_PACKET + 1);

  logic [15:0]      timeout_q;
  logic             req_zero_q;
  phase_e           phase_q, phase_d;
  logic             saw_ff_q, saw_ff_d;
  logic [15:0]      elapsed_q, elapsed_d;
  logic [LenW-1:0]  count_q, count_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       want_id_q, want_id_d;
  logic [LenW-1:0]  want_len_q, want_len_d;
  logic             header_ok_q, header_ok_d;
  logic [7:0]       err_q, err_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             out_valid_q;
  out_word_t        out_q;

  logic             single;
  status_e          single_status;
  logic [7:0]       single_err;
  logic             burst;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [7:0]       rdata;
  logic [15:0]      elapsed_inc;
  logic             len_ok;
  logic             is_ff;
  logic             chk_byte;
  logic [7:0]       b;

  assign b           = in_data_i.rx_byte;
  assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
  assign len_ok      = (in_data_i.expected_len >= 8'(MinPacket)) &&
                       (in_data_i.expected_len <= 8'(MAX_PACKET));
  assign is_ff       = (b == HeaderByte);
  assign chk_byte    = (LenW'(count_q + LenW'(1)) >= want_len_q);
  assign waddr       = AddrW'(count_q - LenW'(5));

  always_comb begin
    phase_d       = phase_q;
    saw_ff_d      = saw_ff_q;
    elapsed_d     = elapsed_q;
    count_d       = count_q;
    sum_d         = sum_q;
    want_id_d     = want_id_q;
    want_len_d    = want_len_q;
    header_ok_d   = header_ok_q;
    err_d         = err_q;
    single        = 1'b0;
    single_status = STS_OK;
    single_err    = err_q;
    burst         = 1'b0;
    we            = 1'b0;
    if (cmd_i.step) begin
      case (cmd_e'(in_data_i.command))
        CMD_ARM: begin
          if (!len_ok) begin
            phase_d       = PH_IDLE;
            single        = 1'b1;
            single_status = STS_BAD_REQ;
            single_err    = 8'd0;
          end else begin
            want_id_d   = in_data_i.servo_id;
            want_len_d  = LenW'(in_data_i.expected_len);
            elapsed_d   = 16'd0;
            saw_ff_d    = 1'b0;
            count_d     = '0;
            sum_d       = 8'd0;
            header_ok_d = 1'b1;
            err_d       = 8'd0;
            phase_d     = PH_HUNT;
          end
        end
        CMD_TICK: begin
          if (phase_q != PH_IDLE) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= timeout_q) begin
              phase_d       = PH_IDLE;
              single        = 1'b1;
              single_status = STS_TIMEOUT;
            end
          end
        end
        CMD_BYTE: begin
          if (phase_q == PH_HUNT) begin
            if (saw_ff_q && is_ff) begin
              phase_d  = PH_COLLECT;
              count_d  = LenW'(2);
              sum_d    = 8'd0;
              saw_ff_d = 1'b0;
            end else begin
              saw_ff_d = is_ff;
            end
          end else if (phase_q == PH_COLLECT) begin
            if (chk_byte) begin
              phase_d = PH_IDLE;
              if (!header_ok_q || (~sum_q != b)) begin
                single        = 1'b1;
                single_status = STS_MISMATCH;
              end else if (want_len_q == LenW'(MinPacket)) begin
                single = 1'b1;
              end else begin
                burst = 1'b1;
              end
            end else begin
              sum_d = sum_q + b;
              if (count_q == LenW'(2)) begin
                if (b != want_id_q) begin
                  header_ok_d = 1'b0;
                end
              end else if (count_q == LenW'(3)) begin
                if (b != (8'(want_len_q) - 8'(LenOverhead))) begin
                  header_ok_d = 1'b0;
                end
              end else if (count_q == LenW'(4)) begin
                err_d = b;
                if (req_zero_q && (b != 8'd0)) begin
                  header_ok_d = 1'b0;
                end
              end else begin
                we = (count_q < LenW'(MAX_PACKET - 1));
              end
              count_d = LenW'(count_q + LenW'(1));
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.step) begin
      idx_d = '0;
    end else if (cmd_i.load_param) begin
      idx_d = AddrW'(idx_q + AddrW'(1));
    end
  end

  assign sts_o.burst_start = burst;
  assign sts_o.idx_last    = (idx_q == AddrW'(want_len_q - LenW'(MinPacket + 1)));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  sspr_ram #(
    .WIDTH (8),
    .DEPTH (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (b),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TimeoutReset;
      req_zero_q  <= 1'b1;
      phase_q     <= PH_IDLE;
      saw_ff_q    <= 1'b0;
      elapsed_q   <= 16'd0;
      count_q     <= '0;
      sum_q       <= 8'd0;
      want_id_q   <= 8'd0;
      want_len_q  <= '0;
      header_ok_q <= 1'b1;
      err_q       <= 8'd0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTimeout: timeout_q  <= cfg_data_i;
          CfgReqZero: req_zero_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      phase_q     <= phase_d;
      saw_ff_q    <= saw_ff_d;
      elapsed_q   <= elapsed_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      want_id_q   <= want_id_d;
      want_len_q  <= want_len_d;
      header_ok_q <= header_ok_d;
      err_q       <= err_d;
      idx_q       <= idx_d;
      if (single || cmd_i.load_param) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the word until a new one is loaded
  always_ff @(posedge clk_i) begin
    if (single) begin
      out_q.status       <= single_status;
      out_q.device_error <= single_err;
      out_q.has_param    <= 1'b0;
      out_q.param_index  <= 6'd0;
      out_q.param_byte   <= 8'd0;
      out_q.last         <= 1'b1;
    end else if (cmd_i.load_param) begin
      out_q.status       <= STS_OK;
      out_q.device_error <= err_q;
      out_q.has_param    <= 1'b1;
      out_q.param_index  <= 6'(idx_q);
      out_q.param_byte   <= rdata;
      out_q.last         <= sts_o.idx_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/sspr_checker.sv @@
// ----------------------------------------------------------------------------
// sspr_checker: port checks of the servo status packet receiver
// Watches the top level channels and flags broken result sequencing.
// ----------------------------------------------------------------------------
module sspr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input sspr_pkg::out_word_t out_data_i
);
  import sspr_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("result word changed while stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |-> (!out_valid_i || out_ready_i))
    else $error("input word taken while a result word is blocked");

  a_burst_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !out_data_i.last) |-> !in_ready_i)
    else $error("input taken in the middle of a parameter burst");

  a_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_data_i.has_param) |->
      (out_data_i.last && (out_data_i.param_index == 6'd0) &&
       (out_data_i.param_byte == 8'd0)))
    else $error("malformed status-only word");

  a_param_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.has_param) |-> (out_data_i.status == STS_OK))
    else $error("parameter word with failing status");

endmodule

bind servo_status_packet_receiver sspr_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);
